FILE: hdl/irpfd_pkg.sv
// shared constants and types of the ir pulse distance frame decoder
`timescale 1ns / 1ps

package irpfd_pkg;

   localparam int ADDR_BITS  = 5;
   localparam int CMD_BITS   = 10;
   localparam int FRAME_BITS = ADDR_BITS + CMD_BITS;
   localparam int TICK_W     = 15;
   localparam int POS_W      = 4;
   localparam int CSR_IDX_W  = 3;

   localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_BITS);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BITS - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERTED_POLARITY = 3'd0,
      CSR_MARGIN_TICKS      = 3'd1,
      CSR_ZERO_MARK_TICKS   = 3'd2,
      CSR_ZERO_SPACE_TICKS  = 3'd3,
      CSR_ONE_MARK_TICKS    = 3'd4,
      CSR_ONE_SPACE_TICKS   = 3'd5
   } csr_index_type;

   // one classified word handed from the input stage to the frame assembler
   typedef struct packed {
      logic valid;
      logic frame_start;
      logic bit_value;
   } item_ctrl_type;

endpackage

FILE: hdl/irpfd_symbol_match.sv
// compares one pulse word against one symbol's mark and space window
`timescale 1ns / 1ps

module irpfd_symbol_match
   import irpfd_pkg::*;
(
   input  logic              polarity,
   input  logic [TICK_W-1:0] margin,
   input  logic [TICK_W-1:0] mark_target,
   input  logic [TICK_W-1:0] space_target,
   input  logic              first_level,
   input  logic [TICK_W-1:0] first_ticks,
   input  logic              second_level,
   input  logic [TICK_W-1:0] second_ticks,
   output logic              match
);

   function automatic logic in_window(input logic [TICK_W-1:0] raw,
                                      input logic [TICK_W-1:0] target,
                                      input logic [TICK_W-1:0] tol);
      logic [TICK_W:0]   hi;
      logic [TICK_W-1:0] lo;
      hi = {1'b0, target} + {1'b0, tol};
      lo = target - tol;
      // a margin above the target never matches
      in_window = (tol <= target) && ({1'b0, raw} < hi) && (raw > lo);
   endfunction

   assign match = (first_level == polarity) && (second_level != polarity) &&
                  in_window(first_ticks, mark_target, margin) &&
                  in_window(second_ticks, space_target, margin);

endmodule

FILE: hdl/irpfd_frame_asm.sv
// bit position tracking, address and command assembly and the result register
`timescale 1ns / 1ps

module irpfd_frame_asm
   import irpfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  item_ctrl_type        item,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_BITS-1:0] rsp_address,
   output logic [CMD_BITS-1:0]  rsp_command
);

   logic [POS_W-1:0]     pos_ff, pos_in, pos_eff;
   logic [ADDR_BITS-1:0] addr_ff, addr_in, addr_eff;
   logic [CMD_BITS-1:0]  cmd_ff, cmd_in, cmd_eff;
   logic                 rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_address_ff;
   logic [CMD_BITS-1:0]  rsp_command_ff;
   logic                 active, finish;

   always_comb begin
      pos_eff  = item.frame_start ? '0 : pos_ff;
      addr_eff = item.frame_start ? '0 : addr_ff;
      cmd_eff  = item.frame_start ? '0 : cmd_ff;
      active   = (pos_eff != POS_IDLE);
      for (int i = 0; i < ADDR_BITS; i++) begin
         addr_in[i] = addr_eff[i] |
                      (active && item.bit_value && (pos_eff == POS_W'(i)));
      end
      for (int i = 0; i < CMD_BITS; i++) begin
         cmd_in[i] = cmd_eff[i] |
                     (active && item.bit_value && (pos_eff == POS_W'(i + ADDR_BITS)));
      end
      pos_in = active ? pos_eff + 1'b1 : pos_eff;
      finish = active && (pos_eff == POS_LAST);
      // a word that closes a frame waits for room in the result register
      take   = item.valid && (!finish || !rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_IDLE;
         addr_ff      <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            pos_ff  <= pos_in;
            addr_ff <= addr_in;
            cmd_ff  <= cmd_in;
         end
         if (take && finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && finish) begin
         rsp_address_ff <= addr_in;
         rsp_command_ff <= cmd_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_command = rsp_command_ff;

endmodule

FILE: hdl/ir_pulse_distance_frame_decoder_unit.sv
// top level of the ir pulse distance frame decoder
`timescale 1ns / 1ps

// usage
//   req_ channel: one captured pulse word per handshake (valid high, stall low)
//   rsp_ channel: one word with address and command per completed frame
//   csr_ port: write enable, register index and data, taken at any enabled edge;
//   write only while no frame word is in flight
// timing
//   a word is registered at the input, classified by the two symbol
//   comparators and folded into the frame when the assembler takes it; a
//   result is written to the rsp_ register as the assembler takes the fifteenth
//   word and leaves once rsp_stall is low
//   throughput is one word per cycle while no frame-closing word waits,
//   set by the single input register feeding the frame assembler
// stall
//   the result register holds while rsp_stall is high; words that do not
//   finish a frame keep flowing, and only a frame-closing word waits, which
//   then raises req_stall
// reset
//   clears all csr registers to zero, empties both stages and puts the bit
//   position in idle, so words are ignored until one marks a frame start
module ir_pulse_distance_frame_decoder_unit
   import irpfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_frame_start,
   input  logic                 req_first_level,
   input  logic [TICK_W-1:0]    req_first_ticks,
   input  logic                 req_second_level,
   input  logic [TICK_W-1:0]    req_second_ticks,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_BITS-1:0] rsp_address,
   output logic [CMD_BITS-1:0]  rsp_command
);

   // csr registers
   logic              polarity_ff;
   logic [TICK_W-1:0] margin_ff, zero_mark_ff, zero_space_ff, one_mark_ff, one_space_ff;

   // input stage
   logic              in_valid_ff;
   logic              in_start_ff, in_l0_ff, in_l1_ff;
   logic [TICK_W-1:0] in_d0_ff, in_d1_ff;

   logic          zero_hit, one_hit, take;
   item_ctrl_type item;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff   <= 1'b0;
         margin_ff     <= '0;
         zero_mark_ff  <= '0;
         zero_space_ff <= '0;
         one_mark_ff   <= '0;
         one_space_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INVERTED_POLARITY: polarity_ff   <= csr_data[0];
            CSR_MARGIN_TICKS:      margin_ff     <= csr_data;
            CSR_ZERO_MARK_TICKS:   zero_mark_ff  <= csr_data;
            CSR_ZERO_SPACE_TICKS:  zero_space_ff <= csr_data;
            CSR_ONE_MARK_TICKS:    one_mark_ff   <= csr_data;
            CSR_ONE_SPACE_TICKS:   one_space_ff  <= csr_data;
            default: ; // unknown index, dropped
         endcase
      end
   end

   // input register refills whenever it is empty or its word moves on
   assign req_stall = in_valid_ff && !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_start_ff <= req_frame_start;
         in_l0_ff    <= req_first_level;
         in_d0_ff    <= req_first_ticks;
         in_l1_ff    <= req_second_level;
         in_d1_ff    <= req_second_ticks;
      end
   end

   irpfd_symbol_match u_zero_match (
      .polarity     (polarity_ff),
      .margin       (margin_ff),
      .mark_target  (zero_mark_ff),
      .space_target (zero_space_ff),
      .first_level  (in_l0_ff),
      .first_ticks  (in_d0_ff),
      .second_level (in_l1_ff),
      .second_ticks (in_d1_ff),
      .match        (zero_hit)
   );

   irpfd_symbol_match u_one_match (
      .polarity     (polarity_ff),
      .margin       (margin_ff),
      .mark_target  (one_mark_ff),
      .space_target (one_space_ff),
      .first_level  (in_l0_ff),
      .first_ticks  (in_d0_ff),
      .second_level (in_l1_ff),
      .second_ticks (in_d1_ff),
      .match        (one_hit)
   );

   // zero has priority; no match leaves a zero bit
   always_comb begin
      item.valid       = in_valid_ff;
      item.frame_start = in_start_ff;
      item.bit_value   = one_hit && !zero_hit;
   end

   irpfd_frame_asm u_frame_asm (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_address (rsp_address),
      .rsp_command (rsp_command)
   );

endmodule
